// ===== rtl/hpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types, micro-op table and saturation helpers of the pose composer.
// ----------------------------------------------------------------------------
package hpc_pkg;

    localparam int unsigned OpBits  = 36;  // wide operand of the shared multiplier
    localparam int unsigned AccBits = 56;  // accumulator width
    localparam int unsigned NumUops = 31;  // micro-ops per level

    typedef enum logic [2:0] {
        CFG_POS_X, CFG_POS_Y, CFG_POS_Z, CFG_ROT, CFG_SCALE, CFG_VISIBLE, CFG_MASK
    } t_cfg_idx;

    typedef enum logic [3:0] {
        B_P0, B_P1, B_P2, B_T0, B_T1, B_T2, B_R0, B_R1, B_R2, B_R3
    } t_bsel;

    typedef enum logic [3:0] {
        D_T0, D_T1, D_T2, D_X0, D_X1, D_X2, D_W0, D_W1, D_W2, D_W3
    } t_dst;

    typedef struct packed {
        logic       valid;
        logic [1:0] a_sel;
        t_bsel      b_sel;
        logic       neg;
        logic       first;
        logic       last;
        t_dst       dst;
    } t_uop;

    function automatic t_uop mk(input logic [1:0] a, input t_bsel b, input logic n,
                                input logic f, input logic l, input t_dst d);
        t_uop u;
        u.valid = 1'b1;
        u.a_sel = a;
        u.b_sel = b;
        u.neg   = n;
        u.first = f;
        u.last  = l;
        u.dst   = d;
        return u;
    endfunction

    // rotate by cross products, then Hamilton product
    function automatic t_uop uop_at(input logic [4:0] step);
        t_uop u;
        u = '0;
        case (step)
            5'd0:  u = mk(2'd2, B_P2, 1'b0, 1'b1, 1'b0, D_T0);
            5'd1:  u = mk(2'd3, B_P1, 1'b1, 1'b0, 1'b1, D_T0);
            5'd2:  u = mk(2'd3, B_P0, 1'b0, 1'b1, 1'b0, D_T1);
            5'd3:  u = mk(2'd1, B_P2, 1'b1, 1'b0, 1'b1, D_T1);
            5'd4:  u = mk(2'd1, B_P1, 1'b0, 1'b1, 1'b0, D_T2);
            5'd5:  u = mk(2'd2, B_P0, 1'b1, 1'b0, 1'b1, D_T2);
            5'd6:  u = mk(2'd0, B_T0, 1'b0, 1'b1, 1'b0, D_X0);
            5'd7:  u = mk(2'd2, B_T2, 1'b0, 1'b0, 1'b0, D_X0);
            5'd8:  u = mk(2'd3, B_T1, 1'b1, 1'b0, 1'b1, D_X0);
            5'd9:  u = mk(2'd0, B_T1, 1'b0, 1'b1, 1'b0, D_X1);
            5'd10: u = mk(2'd3, B_T0, 1'b0, 1'b0, 1'b0, D_X1);
            5'd11: u = mk(2'd1, B_T2, 1'b1, 1'b0, 1'b1, D_X1);
            5'd12: u = mk(2'd0, B_T2, 1'b0, 1'b1, 1'b0, D_X2);
            5'd13: u = mk(2'd1, B_T1, 1'b0, 1'b0, 1'b0, D_X2);
            5'd14: u = mk(2'd2, B_T0, 1'b1, 1'b0, 1'b1, D_X2);
            5'd15: u = mk(2'd0, B_R0, 1'b0, 1'b1, 1'b0, D_W0);
            5'd16: u = mk(2'd1, B_R1, 1'b1, 1'b0, 1'b0, D_W0);
            5'd17: u = mk(2'd2, B_R2, 1'b1, 1'b0, 1'b0, D_W0);
            5'd18: u = mk(2'd3, B_R3, 1'b1, 1'b0, 1'b1, D_W0);
            5'd19: u = mk(2'd0, B_R1, 1'b0, 1'b1, 1'b0, D_W1);
            5'd20: u = mk(2'd1, B_R0, 1'b0, 1'b0, 1'b0, D_W1);
            5'd21: u = mk(2'd2, B_R3, 1'b0, 1'b0, 1'b0, D_W1);
            5'd22: u = mk(2'd3, B_R2, 1'b1, 1'b0, 1'b1, D_W1);
            5'd23: u = mk(2'd0, B_R2, 1'b0, 1'b1, 1'b0, D_W2);
            5'd24: u = mk(2'd1, B_R3, 1'b1, 1'b0, 1'b0, D_W2);
            5'd25: u = mk(2'd2, B_R0, 1'b0, 1'b0, 1'b0, D_W2);
            5'd26: u = mk(2'd3, B_R1, 1'b0, 1'b0, 1'b1, D_W2);
            5'd27: u = mk(2'd0, B_R3, 1'b0, 1'b1, 1'b0, D_W3);
            5'd28: u = mk(2'd1, B_R2, 1'b0, 1'b0, 1'b0, D_W3);
            5'd29: u = mk(2'd2, B_R1, 1'b1, 1'b0, 1'b0, D_W3);
            5'd30: u = mk(2'd3, B_R0, 1'b0, 1'b0, 1'b1, D_W3);
            default: u = '0;
        endcase
        return u;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -48'sh0000_8000_0000) return -32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [41:0] v);
        if (v > 42'sh7FFF) return 16'sh7FFF;
        if (v < -42'sh8000) return -16'sh8000;
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hierarchical_pose_composer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchical_pose_composer
// Composes each part pose through its parent chain and the model pose.
//
// channel   dir  handshake            content
// s_axis    in   i_s_tvalid/o_tready  part pose, first_part on tuser
// m_axis    out  o_m_tvalid/i_tready  world pose, saturated on tuser
// cfg       in   i_cfg_wen            model registers by index
//
// Each item passes from transfer to transfer through, for every ancestor
// walked, a check, a store read and 32 steps, then for the model pose a
// check and 32 steps, then a hand-off and the idle state. Each level
// runs 31 micro-ops through the single 16x36 multiply-accumulate unit.
// Synchronous active-low reset clears control registers and sets the model
// registers to their defaults. Input is taken only when idle; a result holds
// in the output register until transferred, and a finished item waits only
// while that register is still full.
// ----------------------------------------------------------------------------
module hierarchical_pose_composer #(
    parameter int MAX_PARTS = 256,
    parameter int MASK_BITS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wen,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [63:0]  i_cfg_wdata,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // parent_index, local_x, local_y, local_z, local_qw, local_qx, local_qy,
    // local_qz, part_visible, part_camera_mask, part_scale, zero fill
    input  wire logic [239:0] i_s_tdata,
    // first_part
    input  wire logic [0:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // world_x, world_y, world_z, world_qw, world_qx, world_qy, world_qz,
    // out_visible, out_camera_mask, out_scale, zero fill
    output logic [231:0]      o_m_tdata,
    // saturated
    output logic [0:0]        o_m_tuser
);

    localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam int XW = (CW > 8) ? CW : 8;
    localparam logic [31:0] MMASK = (MASK_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << MASK_BITS) - 64'd1);

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_LOAD, S_RUN, S_OUT} t_state;

    typedef struct packed {
        logic [7:0]  parent;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [63:0] rot;
    } t_entry;

    t_entry r_mem [MAX_PARTS];
    t_entry r_rd;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [XW-1:0] r_child, r_p;
    logic [7:0]    r_nparent;
    logic          r_final;
    logic [4:0]    r_step;
    logic          r_clip;

    logic [31:0] r_mpos_x, r_mpos_y, r_mpos_z;
    logic [63:0] r_mrot;
    logic [31:0] r_mscale, r_mmask;
    logic        r_mvis;

    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_base [3];
    logic signed [15:0] r_rot [4];
    logic signed [15:0] r_nrot [3];
    logic signed [15:0] r_pq [4];
    logic signed [hpc_pkg::OpBits-1:0] r_t [3];

    logic        r_vis;
    logic [31:0] r_mask;
    logic [63:0] r_sprod;
    logic [31:0] r_scale;

    logic         r_m_tvalid;
    logic [231:0] r_m_tdata;
    logic [0:0]   r_m_tuser;

    logic [CW-1:0] idx;
    logic          store;
    logic          accept;
    logic          out_load;
    hpc_pkg::t_uop uop, wuop;
    logic signed [15:0] op_a;
    logic signed [hpc_pkg::OpBits-1:0] op_b;
    logic signed [hpc_pkg::AccBits-1:0] sum;
    logic signed [41:0] shr;
    logic signed [47:0] pos_wide;
    logic signed [31:0] pos_sat;
    logic signed [15:0] rot_sat;
    logic [1:0]         xi;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_OUT) && (!r_m_tvalid || i_m_tready);
    assign idx        = i_s_tuser[0] ? '0 : r_count;
    assign store      = idx < CW'(MAX_PARTS);
    assign uop        = (r_state == S_RUN) ? hpc_pkg::uop_at(r_step) : '0;
    assign op_a       = r_pq[uop.a_sel];

    always_comb begin
        case (uop.b_sel)
            hpc_pkg::B_P0: op_b = hpc_pkg::OpBits'(r_pos[0]);
            hpc_pkg::B_P1: op_b = hpc_pkg::OpBits'(r_pos[1]);
            hpc_pkg::B_P2: op_b = hpc_pkg::OpBits'(r_pos[2]);
            hpc_pkg::B_T0: op_b = r_t[0];
            hpc_pkg::B_T1: op_b = r_t[1];
            hpc_pkg::B_T2: op_b = r_t[2];
            hpc_pkg::B_R0: op_b = hpc_pkg::OpBits'(r_rot[0]);
            hpc_pkg::B_R1: op_b = hpc_pkg::OpBits'(r_rot[1]);
            hpc_pkg::B_R2: op_b = hpc_pkg::OpBits'(r_rot[2]);
            hpc_pkg::B_R3: op_b = hpc_pkg::OpBits'(r_rot[3]);
            default:       op_b = '0;
        endcase
    end

    hpc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uop   (uop),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_uop   (wuop),
        .o_sum   (sum)
    );

    always_comb begin
        case (wuop.dst)
            hpc_pkg::D_X1: xi = 2'd1;
            hpc_pkg::D_X2: xi = 2'd2;
            default:       xi = 2'd0;
        endcase
    end

    assign shr      = sum[hpc_pkg::AccBits-1:14];
    assign pos_wide = 48'(r_base[xi]) + 48'(r_pos[xi]) + 48'(shr);
    assign pos_sat  = hpc_pkg::sat32(pos_wide);
    assign rot_sat  = hpc_pkg::sat16(shr);

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_p[AW-1:0]];
        if (accept && store) begin
            r_mem[idx[AW-1:0]] <= '{parent: i_s_tdata[7:0], x: i_s_tdata[39:8],
                                   y: i_s_tdata[71:40], z: i_s_tdata[103:72],
                                   rot: {i_s_tdata[119:104], i_s_tdata[135:120],
                                         i_s_tdata[151:136], i_s_tdata[167:152]}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_mpos_x   <= '0;
            r_mpos_y   <= '0;
            r_mpos_z   <= '0;
            r_mrot     <= 64'h4000_0000_0000_0000;
            r_mscale   <= 32'h0001_0000;
            r_mvis     <= 1'b1;
            r_mmask    <= 32'hFFFF_FFFF;
            r_step     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    hpc_pkg::CFG_POS_X:   r_mpos_x <= i_cfg_wdata[31:0];
                    hpc_pkg::CFG_POS_Y:   r_mpos_y <= i_cfg_wdata[31:0];
                    hpc_pkg::CFG_POS_Z:   r_mpos_z <= i_cfg_wdata[31:0];
                    hpc_pkg::CFG_ROT:     r_mrot   <= i_cfg_wdata;
                    hpc_pkg::CFG_SCALE:   r_mscale <= i_cfg_wdata[31:0];
                    hpc_pkg::CFG_VISIBLE: r_mvis   <= i_cfg_wdata[0];
                    hpc_pkg::CFG_MASK:    r_mmask  <= i_cfg_wdata[31:0];
                    default: ;
                endcase
            end

            // write back finished accumulations
            if (wuop.valid && wuop.last) begin
                case (wuop.dst)
                    hpc_pkg::D_T0: r_t[0] <= {sum[48:14], 1'b0};
                    hpc_pkg::D_T1: r_t[1] <= {sum[48:14], 1'b0};
                    hpc_pkg::D_T2: r_t[2] <= {sum[48:14], 1'b0};
                    hpc_pkg::D_X0, hpc_pkg::D_X1, hpc_pkg::D_X2: begin
                        r_pos[xi] <= pos_sat;
                        if (48'(pos_sat) != pos_wide) r_clip <= 1'b1;
                    end
                    hpc_pkg::D_W0, hpc_pkg::D_W1, hpc_pkg::D_W2: begin
                        r_nrot[2'(wuop.dst - hpc_pkg::D_W0)] <= rot_sat;
                        if (42'(rot_sat) != shr) r_clip <= 1'b1;
                    end
                    hpc_pkg::D_W3: begin
                        r_rot[0] <= r_nrot[0];
                        r_rot[1] <= r_nrot[1];
                        r_rot[2] <= r_nrot[2];
                        r_rot[3] <= rot_sat;
                        if (42'(rot_sat) != shr) r_clip <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (out_load) begin
                r_m_tvalid <= 1'b1;
                r_m_tdata  <= {7'd0, r_scale, r_mask, r_vis, r_rot[3], r_rot[2],
                               r_rot[1], r_rot[0], r_pos[2], r_pos[1], r_pos[0]};
                r_m_tuser  <= r_clip;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count  <= store ? idx + 1'b1 : CW'(MAX_PARTS);
                        r_child  <= XW'(idx);
                        r_p      <= XW'(i_s_tdata[7:0]);
                        r_pos[0] <= i_s_tdata[39:8];
                        r_pos[1] <= i_s_tdata[71:40];
                        r_pos[2] <= i_s_tdata[103:72];
                        r_rot[0] <= i_s_tdata[119:104];
                        r_rot[1] <= i_s_tdata[135:120];
                        r_rot[2] <= i_s_tdata[151:136];
                        r_rot[3] <= i_s_tdata[167:152];
                        r_vis    <= i_s_tdata[168] & r_mvis;
                        r_mask   <= i_s_tdata[200:169] & r_mmask & MMASK;
                        r_sprod  <= 64'(i_s_tdata[232:201]) * 64'(r_mscale);
                        r_clip   <= 1'b0;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_step <= '0;
                    if (r_p < r_child && r_p < XW'(MAX_PARTS)) begin
                        r_final <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_final   <= 1'b1;
                        r_base[0] <= r_mpos_x;
                        r_base[1] <= r_mpos_y;
                        r_base[2] <= r_mpos_z;
                        r_pq[0]   <= r_mrot[63:48];
                        r_pq[1]   <= r_mrot[47:32];
                        r_pq[2]   <= r_mrot[31:16];
                        r_pq[3]   <= r_mrot[15:0];
                        r_state   <= S_RUN;
                    end
                end
                S_LOAD: begin
                    r_base[0] <= r_rd.x;
                    r_base[1] <= r_rd.y;
                    r_base[2] <= r_rd.z;
                    r_pq[0]   <= r_rd.rot[63:48];
                    r_pq[1]   <= r_rd.rot[47:32];
                    r_pq[2]   <= r_rd.rot[31:16];
                    r_pq[3]   <= r_rd.rot[15:0];
                    r_nparent <= r_rd.parent;
                    r_state   <= S_RUN;
                end
                S_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'(hpc_pkg::NumUops)) begin
                        if (r_final) begin
                            if (r_sprod[63:48] != '0) begin
                                r_scale <= 32'hFFFF_FFFF;
                                r_clip  <= 1'b1;
                            end else begin
                                r_scale <= r_sprod[47:16];
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_child <= r_p;
                            r_p     <= XW'(r_nparent);
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // unused tdata fill bits
    logic unused_fill;
    assign unused_fill = ^i_s_tdata[239:233];

endmodule
`default_nettype wire

// ===== rtl/hpc_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpc_mac
// Shared multiply-accumulate unit: registered product, then signed accumulate.
// ----------------------------------------------------------------------------
module hpc_mac (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire hpc_pkg::t_uop                         i_uop,
    input  wire logic signed [15:0]                    i_a,
    input  wire logic signed [hpc_pkg::OpBits-1:0]     i_b,
    output hpc_pkg::t_uop                              o_uop,
    output logic signed [hpc_pkg::AccBits-1:0]         o_sum
);

    logic signed [hpc_pkg::OpBits+15:0]  r_prod;
    logic signed [hpc_pkg::AccBits-1:0]  r_acc;
    hpc_pkg::t_uop                       r_uop;
    logic signed [hpc_pkg::AccBits-1:0]  prod_x;
    logic signed [hpc_pkg::AccBits-1:0]  base;

    assign prod_x = hpc_pkg::AccBits'(r_prod);
    assign base   = r_uop.first ? '0 : r_acc;
    assign o_sum  = r_uop.neg ? base - prod_x : base + prod_x;
    assign o_uop  = r_uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uop <= '0;
        end else begin
            r_uop <= i_uop;
        end
        r_prod <= i_a * i_b;
        if (r_uop.valid) begin
            r_acc <= o_sum;
        end
    end

endmodule
`default_nettype wire
